>>> rtl/core/pse_pkg.sv
// shared types, constants and helper functions of the particle spawn and retire engine
package pse_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 1024;

  localparam logic [11:0] DT_CAP         = 12'd3277;
  localparam logic [31:0] SEED_DEFAULT   = 32'h584A4945;
  localparam logic [7:0]  FRAME_SPAWN_CAP = 8'd128;
  localparam logic [27:0] DEBT_CAP       = 28'd131072;
  localparam logic [31:0] LIFETIME_FLOOR = 32'd655;
  localparam logic [31:0] DISTANCE_FLOOR = 32'd6554;
  localparam logic [16:0] ONE_Q16        = 17'd65536;
  localparam logic [23:0] DRAW_MASK      = 24'hFFFFFF;
  localparam logic [3:0]  DRAW_LAST      = 4'd8;
  localparam logic [3:0]  DRAW_LIFE      = 4'd6;
  localparam logic [4:0]  SQRT_LAST      = 5'd31;
  localparam logic [4:0]  DIV_LAST       = 5'd16;

  typedef enum logic [2:0] {
    CFG_SPAWN_RATE    = 3'd0,
    CFG_MAX_ALIVE     = 3'd1,
    CFG_SPAWN_DIST    = 3'd2,
    CFG_FADE_START    = 3'd3,
    CFG_LIFETIME_LOW  = 3'd4,
    CFG_LIFETIME_HIGH = 3'd5,
    CFG_RANDOM_SEED   = 3'd6
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_AGE_RD,
    ST_AGE_CHK,
    ST_MOVE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQ_M,
    ST_CULL,
    ST_SQRT,
    ST_FADE,
    ST_DIV,
    ST_DIVEND,
    ST_SCALE,
    ST_COMB,
    ST_RATE,
    ST_DEBT,
    ST_WANT,
    ST_SPAWN,
    ST_DRAW,
    ST_LMUL,
    ST_LWR,
    ST_DONE
  } state_t;

  function automatic logic [31:0] xs_next(input logic [31:0] s);
    logic [31:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return (x == 32'd0) ? SEED_DEFAULT : x;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

>>> rtl/core/pse_ifs.sv
// item channel and configuration interfaces

interface pse_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] frame_dt;
  logic [31:0] camera_dx;
  logic [31:0] camera_dy;
  logic [31:0] camera_dz;
  logic        emitter_visible;
  logic [31:0] density_scale;
  modport source (output valid, frame_dt, camera_dx, camera_dy, camera_dz,
                  emitter_visible, density_scale, input ready);
  modport sink (input valid, frame_dt, camera_dx, camera_dy, camera_dz,
                emitter_visible, density_scale, output ready);
endinterface

interface pse_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] retired_count;
  logic [7:0]  spawned_count;
  logic [7:0]  dropped_count;
  logic        culled;
  logic [16:0] alive_count;
  modport source (output valid, retired_count, spawned_count, dropped_count, culled,
                  alive_count, input ready);
  modport sink (input valid, retired_count, spawned_count, dropped_count, culled,
                alive_count, output ready);
endinterface

interface pse_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

>>> rtl/core/pse_mul.sv
// shared registered 32 by 32 unsigned multiplier
module pse_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= {32'd0, a} * {32'd0, b};
  end
endmodule

>>> rtl/core/pse_slot_mem.sv
// particle age and lifetime store, one write and one registered read port
module pse_slot_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_age,
  input  logic [31:0]   wr_life,
  output logic [31:0]   rd_age_r,
  output logic [31:0]   rd_life_r
);
  logic [31:0] age_mem  [DEPTH];
  logic [31:0] life_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      age_mem[wr_addr]  <= wr_age;
      life_mem[wr_addr] <= wr_life;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_age_r  <= age_mem[rd_addr];
      rd_life_r <= life_mem[rd_addr];
    end
  end
endmodule

>>> rtl/core/particle_spawn_retire_engine_top.sv
// top level: frame sequencer, slot sweep, distance, fade and spawn datapath
// order of work: slot sweep with an age check per live slot and a move per retired slot, then
//   distance squares and cull test, then unless culled square root, fade set-up, fade division
//   if needed, spawn debt, draws and a slot write per spawned particle, a drop per dropped spawn
// throughput: one item at a time; the shared multiplier and the slot sweep set the rate
// reset: synchronous; clears live count and debt, sets config and seed defaults; slot store not cleared
module particle_spawn_retire_engine_top #(
  parameter int unsigned SLOT_COUNT = pse_pkg::SLOT_COUNT_DEF
) (
  input logic      clk,
  input logic      rst_n,
  pse_in_if.sink   in_if,
  pse_out_if.source out_if,
  pse_cfg_if.sink  cfg_if
);
  import pse_pkg::*;

  localparam int unsigned AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned LW = $clog2(SLOT_COUNT + 1);
  localparam logic [16:0] SLOTS17 = 17'(SLOT_COUNT);

  state_t state_r, state_nxt;

  logic [31:0] rate_r, rate_nxt;
  logic [16:0] max_alive_r, max_alive_nxt;
  logic [31:0] spawn_dist_r, spawn_dist_nxt;
  logic [31:0] fade_start_r, fade_start_nxt;
  logic [31:0] life_lo_r, life_lo_nxt;
  logic [31:0] life_hi_r, life_hi_nxt;

  logic [LW-1:0] live_r, live_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [27:0]   debt_r, debt_nxt;
  logic [31:0]   gen_r, gen_nxt;

  logic [11:0] dt_r, dt_nxt;
  logic        vis_r, vis_nxt;
  logic [31:0] ax_r, ax_nxt, ay_r, ay_nxt, az_r, az_nxt;
  logic [16:0] dens_r, dens_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] sq_v_r, sq_v_nxt;
  logic [63:0] sq_res_r, sq_res_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] div_d_r, div_d_nxt;
  logic [16:0] q_r, q_nxt;
  logic [16:0] scale_r, scale_nxt;
  logic [7:0]  want_r, want_nxt;
  logic [7:0]  sp_cnt_r, sp_cnt_nxt;
  logic [3:0]  draw_r, draw_nxt;
  logic [23:0] rsel_r, rsel_nxt;
  logic [16:0] retired_r, retired_nxt;
  logic [7:0]  spawned_r, spawned_nxt;
  logic [7:0]  dropped_r, dropped_nxt;
  logic        culled_r, culled_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [16:0] o_ret_r, o_ret_nxt, o_alive_r, o_alive_nxt;
  logic [7:0]  o_sp_r, o_sp_nxt, o_dr_r, o_dr_nxt;
  logic        o_cull_r, o_cull_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic          mem_rd_en, mem_we;
  logic [AW-1:0] mem_rd_addr, mem_wr_addr;
  logic [31:0]   mem_wr_age, mem_wr_life, rd_age, rd_life;

  logic [31:0] maxd, fade;
  logic [32:0] age_sum;
  logic [31:0] age_new;
  logic [63:0] sq_bit, sq_t;
  logic [32:0] div_t;
  logic        div_ge;
  logic [27:0] debt_sum;
  logic [11:0] debt_whole;
  logic [14:0] ma_quarter;
  logic [7:0]  spawn_cap;
  logic [16:0] limit;
  logic [31:0] lo_sel, hi_sel, life_val;
  logic [31:0] gen_step;
  logic [LW-1:0] last_idx;
  logic        cfg_wr, in_acc, out_free;

  pse_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  pse_slot_mem #(
    .DEPTH (SLOT_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .rd_en     (mem_rd_en),
    .rd_addr   (mem_rd_addr),
    .we        (mem_we),
    .wr_addr   (mem_wr_addr),
    .wr_age    (mem_wr_age),
    .wr_life   (mem_wr_life),
    .rd_age_r  (rd_age),
    .rd_life_r (rd_life)
  );

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && in_if.ready;
  assign cfg_wr       = cfg_if.valid && cfg_if.ready;
  assign out_free     = !out_valid_r || out_if.ready;

  assign out_if.valid         = out_valid_r;
  assign out_if.retired_count = o_ret_r;
  assign out_if.spawned_count = o_sp_r;
  assign out_if.dropped_count = o_dr_r;
  assign out_if.culled        = o_cull_r;
  assign out_if.alive_count   = o_alive_r;

  // shared helper values
  always_comb begin
    maxd       = (spawn_dist_r < DISTANCE_FLOOR) ? DISTANCE_FLOOR : spawn_dist_r;
    fade       = (fade_start_r < maxd) ? fade_start_r : maxd;
    age_sum    = {1'b0, rd_age} + {21'd0, dt_r};
    age_new    = age_sum[32] ? 32'hFFFFFFFF : age_sum[31:0];
    sq_bit     = 64'd1 << {(5'd31 - cnt_r), 1'b0};
    sq_t       = sq_res_r + sq_bit;
    div_t      = (cnt_r == 5'd0) ? rem_r : {rem_r[31:0], 1'b0};
    div_ge     = div_t >= {1'b0, div_d_r};
    debt_sum   = debt_r + mul_p[59:32];
    debt_whole = debt_r[27:16];
    ma_quarter = max_alive_r[16:2];
    if (ma_quarter == 15'd0) begin
      spawn_cap = 8'd1;
    end else if (ma_quarter > {7'd0, FRAME_SPAWN_CAP}) begin
      spawn_cap = FRAME_SPAWN_CAP;
    end else begin
      spawn_cap = ma_quarter[7:0];
    end
    limit = (max_alive_r == 17'd0) ? 17'd1 : max_alive_r;
    if (limit > SLOTS17) begin
      limit = SLOTS17;
    end
    lo_sel   = (life_hi_r < life_lo_r) ? life_hi_r : life_lo_r;
    hi_sel   = (life_hi_r < life_lo_r) ? life_lo_r : life_hi_r;
    life_val = lo_sel + mul_p[55:24];
    if (life_val < LIFETIME_FLOOR) begin
      life_val = LIFETIME_FLOOR;
    end
    gen_step = xs_next(gen_r);
    last_idx = live_r - LW'(1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_acc) state_nxt = ST_AGE_RD;
      ST_AGE_RD:  state_nxt = (idx_r < live_r) ? ST_AGE_CHK : ST_SQ_X;
      ST_AGE_CHK: state_nxt = (age_new >= rd_life) ? ST_MOVE : ST_AGE_RD;
      ST_MOVE:    state_nxt = ST_AGE_RD;
      ST_SQ_X:    state_nxt = ST_SQ_Y;
      ST_SQ_Y:    state_nxt = ST_SQ_Z;
      ST_SQ_Z:    state_nxt = ST_SQ_M;
      ST_SQ_M:    state_nxt = ST_CULL;
      ST_CULL: begin
        if (!vis_r || (acc_r > mul_p) || (dt_r == 12'd0)) state_nxt = ST_DONE;
        else state_nxt = ST_SQRT;
      end
      ST_SQRT:    if (cnt_r == SQRT_LAST) state_nxt = ST_FADE;
      ST_FADE: begin
        if ((sq_res_r[31:0] > fade) && (maxd > fade)) state_nxt = ST_DIV;
        else state_nxt = ST_SCALE;
      end
      ST_DIV:     if (cnt_r == DIV_LAST) state_nxt = ST_DIVEND;
      ST_DIVEND:  state_nxt = ST_SCALE;
      ST_SCALE:   state_nxt = ST_COMB;
      ST_COMB:    state_nxt = ST_RATE;
      ST_RATE:    state_nxt = ST_DEBT;
      ST_DEBT:    state_nxt = ST_WANT;
      ST_WANT:    state_nxt = ST_SPAWN;
      ST_SPAWN: begin
        if (sp_cnt_r == want_r) state_nxt = ST_DONE;
        else if (17'(live_r) < limit) state_nxt = ST_DRAW;
      end
      ST_DRAW:    if (draw_r == DRAW_LAST) state_nxt = ST_LMUL;
      ST_LMUL:    state_nxt = ST_LWR;
      ST_LWR:     state_nxt = ST_SPAWN;
      ST_DONE:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rate_nxt       = rate_r;
    max_alive_nxt  = max_alive_r;
    spawn_dist_nxt = spawn_dist_r;
    fade_start_nxt = fade_start_r;
    life_lo_nxt    = life_lo_r;
    life_hi_nxt    = life_hi_r;
    live_nxt       = live_r;
    idx_nxt        = idx_r;
    debt_nxt       = debt_r;
    gen_nxt        = gen_r;
    dt_nxt         = dt_r;
    vis_nxt        = vis_r;
    ax_nxt         = ax_r;
    ay_nxt         = ay_r;
    az_nxt         = az_r;
    dens_nxt       = dens_r;
    acc_nxt        = acc_r;
    sq_v_nxt       = sq_v_r;
    sq_res_nxt     = sq_res_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    div_d_nxt      = div_d_r;
    q_nxt          = q_r;
    scale_nxt      = scale_r;
    want_nxt       = want_r;
    sp_cnt_nxt     = sp_cnt_r;
    draw_nxt       = draw_r;
    rsel_nxt       = rsel_r;
    retired_nxt    = retired_r;
    spawned_nxt    = spawned_r;
    dropped_nxt    = dropped_r;
    culled_nxt     = culled_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    o_ret_nxt      = o_ret_r;
    o_sp_nxt       = o_sp_r;
    o_dr_nxt       = o_dr_r;
    o_cull_nxt     = o_cull_r;
    o_alive_nxt    = o_alive_r;
    mul_a          = 32'd0;
    mul_b          = 32'd0;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = idx_r[AW-1:0];
    mem_we         = 1'b0;
    mem_wr_addr    = idx_r[AW-1:0];
    mem_wr_age     = age_new;
    mem_wr_life    = rd_life;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          dt_nxt      = (in_if.frame_dt > {20'd0, DT_CAP}) ? DT_CAP : in_if.frame_dt[11:0];
          vis_nxt     = in_if.emitter_visible;
          ax_nxt      = abs32(in_if.camera_dx);
          ay_nxt      = abs32(in_if.camera_dy);
          az_nxt      = abs32(in_if.camera_dz);
          dens_nxt    = (in_if.density_scale > {15'd0, ONE_Q16}) ? ONE_Q16
                                                                 : in_if.density_scale[16:0];
          idx_nxt     = '0;
          acc_nxt     = 64'd0;
          retired_nxt = 17'd0;
          spawned_nxt = 8'd0;
          dropped_nxt = 8'd0;
          culled_nxt  = 1'b0;
        end
      end
      ST_AGE_RD: begin
        mem_rd_en = idx_r < live_r;
      end
      ST_AGE_CHK: begin
        if (age_new >= rd_life) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = last_idx[AW-1:0];
        end else begin
          mem_we  = 1'b1;
          idx_nxt = idx_r + LW'(1);
        end
      end
      ST_MOVE: begin
        mem_we      = 1'b1;
        mem_wr_age  = rd_age;
        live_nxt    = live_r - LW'(1);
        retired_nxt = retired_r + 17'd1;
      end
      ST_SQ_X: begin
        mul_a = ax_r;
        mul_b = ax_r;
      end
      ST_SQ_Y: begin
        acc_nxt = acc_r + mul_p;
        mul_a   = ay_r;
        mul_b   = ay_r;
      end
      ST_SQ_Z: begin
        acc_nxt = acc_r + mul_p;
        mul_a   = az_r;
        mul_b   = az_r;
      end
      ST_SQ_M: begin
        acc_nxt = acc_r + mul_p;
        mul_a   = maxd;
        mul_b   = maxd;
      end
      ST_CULL: begin
        if (!vis_r || (acc_r > mul_p) || (dt_r == 12'd0)) begin
          culled_nxt = 1'b1;
        end else begin
          sq_v_nxt   = acc_r;
          sq_res_nxt = 64'd0;
          cnt_nxt    = 5'd0;
        end
      end
      ST_SQRT: begin
        if (sq_v_r >= sq_t) begin
          sq_v_nxt   = sq_v_r - sq_t;
          sq_res_nxt = (sq_res_r >> 1) + sq_bit;
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        cnt_nxt = cnt_r + 5'd1;
      end
      ST_FADE: begin
        rem_nxt   = {1'b0, sq_res_r[31:0] - fade};
        div_d_nxt = maxd - fade;
        q_nxt     = 17'd0;
        cnt_nxt   = 5'd0;
        scale_nxt = ONE_Q16;
      end
      ST_DIV: begin
        rem_nxt = div_ge ? (div_t - {1'b0, div_d_r}) : div_t;
        q_nxt   = {q_r[15:0], div_ge};
        cnt_nxt = cnt_r + 5'd1;
      end
      ST_DIVEND: begin
        scale_nxt = q_r[16] ? 17'd0 : (ONE_Q16 - q_r);
      end
      ST_SCALE: begin
        mul_a = {15'd0, dens_r};
        mul_b = {15'd0, scale_r};
      end
      ST_COMB: begin
        mul_a = {15'd0, mul_p[32:16]};
        mul_b = {20'd0, dt_r};
      end
      ST_RATE: begin
        mul_a = rate_r;
        mul_b = mul_p[31:0];
      end
      ST_DEBT: begin
        debt_nxt = debt_sum;
      end
      ST_WANT: begin
        if (debt_whole > {4'd0, spawn_cap}) begin
          want_nxt = spawn_cap;
        end else begin
          want_nxt = debt_whole[7:0];
        end
        debt_nxt   = debt_r - {(debt_whole > {4'd0, spawn_cap}) ? {4'd0, spawn_cap}
                                                                 : debt_whole, 16'd0};
        sp_cnt_nxt = 8'd0;
      end
      ST_SPAWN: begin
        if (sp_cnt_r == want_r) begin
          if (debt_r > DEBT_CAP) debt_nxt = DEBT_CAP;
        end else if (17'(live_r) < limit) begin
          draw_nxt = 4'd0;
        end else begin
          dropped_nxt = dropped_r + 8'd1;
          sp_cnt_nxt  = sp_cnt_r + 8'd1;
        end
      end
      ST_DRAW: begin
        gen_nxt  = gen_step;
        if (draw_r == DRAW_LIFE) rsel_nxt = gen_step[23:0] & DRAW_MASK;
        draw_nxt = draw_r + 4'd1;
      end
      ST_LMUL: begin
        mul_a = hi_sel - lo_sel;
        mul_b = {8'd0, rsel_r};
      end
      ST_LWR: begin
        mem_we      = 1'b1;
        mem_wr_addr = live_r[AW-1:0];
        mem_wr_age  = 32'd0;
        mem_wr_life = life_val;
        live_nxt    = live_r + LW'(1);
        spawned_nxt = spawned_r + 8'd1;
        sp_cnt_nxt  = sp_cnt_r + 8'd1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_ret_nxt     = retired_r;
          o_sp_nxt      = spawned_r;
          o_dr_nxt      = dropped_r;
          o_cull_nxt    = culled_r;
          o_alive_nxt   = 17'(live_r);
        end
      end
      default: ;
    endcase

    if (cfg_wr) begin
      case (cfg_if.index)
        CFG_SPAWN_RATE:    rate_nxt = cfg_if.wdata;
        CFG_MAX_ALIVE: begin
          max_alive_nxt = cfg_if.wdata[16:0];
          if (17'(live_r) > cfg_if.wdata[16:0]) begin
            live_nxt = (cfg_if.wdata[16:0] < SLOTS17) ? LW'(cfg_if.wdata[16:0])
                                                      : LW'(SLOTS17);
          end
        end
        CFG_SPAWN_DIST:    spawn_dist_nxt = cfg_if.wdata;
        CFG_FADE_START:    fade_start_nxt = cfg_if.wdata;
        CFG_LIFETIME_LOW:  life_lo_nxt = cfg_if.wdata;
        CFG_LIFETIME_HIGH: life_hi_nxt = cfg_if.wdata;
        CFG_RANDOM_SEED: begin
          live_nxt = '0;
          debt_nxt = 28'd0;
          gen_nxt  = (cfg_if.wdata != 32'd0) ? cfg_if.wdata : SEED_DEFAULT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rate_r       <= 32'd0;
      max_alive_r  <= 17'd1024;
      spawn_dist_r <= 32'd3276800;
      fade_start_r <= 32'd0;
      life_lo_r    <= 32'd65536;
      life_hi_r    <= 32'd131072;
      live_r       <= '0;
      idx_r        <= '0;
      debt_r       <= 28'd0;
      gen_r        <= SEED_DEFAULT;
      cnt_r        <= 5'd0;
      draw_r       <= 4'd0;
      sp_cnt_r     <= 8'd0;
      want_r       <= 8'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rate_r       <= rate_nxt;
      max_alive_r  <= max_alive_nxt;
      spawn_dist_r <= spawn_dist_nxt;
      fade_start_r <= fade_start_nxt;
      life_lo_r    <= life_lo_nxt;
      life_hi_r    <= life_hi_nxt;
      live_r       <= live_nxt;
      idx_r        <= idx_nxt;
      debt_r       <= debt_nxt;
      gen_r        <= gen_nxt;
      cnt_r        <= cnt_nxt;
      draw_r       <= draw_nxt;
      sp_cnt_r     <= sp_cnt_nxt;
      want_r       <= want_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dt_r      <= dt_nxt;
    vis_r     <= vis_nxt;
    ax_r      <= ax_nxt;
    ay_r      <= ay_nxt;
    az_r      <= az_nxt;
    dens_r    <= dens_nxt;
    acc_r     <= acc_nxt;
    sq_v_r    <= sq_v_nxt;
    sq_res_r  <= sq_res_nxt;
    rem_r     <= rem_nxt;
    div_d_r   <= div_d_nxt;
    q_r       <= q_nxt;
    scale_r   <= scale_nxt;
    rsel_r    <= rsel_nxt;
    retired_r <= retired_nxt;
    spawned_r <= spawned_nxt;
    dropped_r <= dropped_nxt;
    culled_r  <= culled_nxt;
    o_ret_r   <= o_ret_nxt;
    o_sp_r    <= o_sp_nxt;
    o_dr_r    <= o_dr_nxt;
    o_cull_r  <= o_cull_nxt;
    o_alive_r <= o_alive_nxt;
  end

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    17'(live_r) <= SLOTS17)
    else $error("live count above slot count");

  a_debt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (debt_r <= DEBT_CAP))
    else $error("spawn debt above cap between items");

  a_sweep_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_AGE_CHK || state_r == ST_MOVE) |-> (idx_r < live_r))
    else $error("sweep index past live count");

  a_spawn_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SPAWN) |-> (sp_cnt_r <= want_r && want_r <= FRAME_SPAWN_CAP))
    else $error("spawn counter out of range");
endmodule

>>> tb/pse_tb_ifs.sv
`timescale 1ns / 1ps
// the testbench channel interfaces are the ones declared with the rtl; nothing is declared here

>>> tb/particle_spawn_retire_engine_top_tb.sv
`timescale 1ns / 1ps
// spawn and retire engine testbench: directed and random frames checked against a count-level predictor
module particle_spawn_retire_engine_top_tb;
  import pse_pkg::*;

  typedef struct packed {
    logic [31:0] frame_dt;
    logic [31:0] camera_dx;
    logic [31:0] camera_dy;
    logic [31:0] camera_dz;
    logic        emitter_visible;
    logic [31:0] density_scale;
  } frame_t;

  typedef struct packed {
    logic [16:0] retired_count;
    logic [7:0]  spawned_count;
    logic [7:0]  dropped_count;
    logic        culled;
    logic [16:0] alive_count;
  } tally_t;

  localparam int SLOTS = 1024;

  logic clk;
  logic rst_n;
  pse_in_if  in_if();
  pse_out_if out_if();
  pse_cfg_if cfg_if();

  particle_spawn_retire_engine_top u_top (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source), .cfg_if(cfg_if.sink)
  );

  // predictor state
  logic [31:0] p_rate, p_max, p_dist, p_fade, p_lo, p_hi;
  logic [31:0] p_age [SLOTS];
  logic [31:0] p_life [SLOTS];
  logic [31:0] p_live, p_debt, p_gen;

  frame_t frame_q[$];
  tally_t tally_q[$];
  int errors = 0;
  bit feed_hold = 0;
  bit cfg_busy = 0;

  function automatic logic [31:0] gen_step();
    logic [31:0] x;
    x = p_gen;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    p_gen = (x == 0) ? 32'h584A4945 : x;
    return p_gen;
  endfunction

  function automatic logic [63:0] sq_mag(input logic [31:0] v);
    logic [63:0] m;
    m = v[31] ? {32'd0, ~v + 32'd1} : {32'd0, v};
    if (v == 32'h80000000) m = 64'h80000000;
    return m * m;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic write_reg_model(input cfg_idx_t idx, input logic [31:0] v);
    case (idx)
      CFG_SPAWN_RATE: p_rate = v;
      CFG_MAX_ALIVE: begin
        p_max = v & 32'h1FFFF;
        if (p_live > p_max) p_live = (p_max < SLOTS) ? p_max : SLOTS;
      end
      CFG_SPAWN_DIST: p_dist = v;
      CFG_FADE_START: p_fade = v;
      CFG_LIFETIME_LOW: p_lo = v;
      CFG_LIFETIME_HIGH: p_hi = v;
      CFG_RANDOM_SEED: begin
        p_live = 0;
        p_debt = 0;
        p_gen = (v != 0) ? v : 32'h584A4945;
      end
      default: ;
    endcase
  endtask

  function automatic tally_t predict_tally(input frame_t f);
    tally_t t;
    logic [31:0] dt, a, maxd, fd, cam_range, scale, dens, comb, want, cap, lim, lo, hi, r, life;
    logic [63:0] dsq, q, lm;
    logic [95:0] inc;
    int idx;
    t = '0;
    dt = (f.frame_dt > 32'd3277) ? 32'd3277 : f.frame_dt;
    idx = 0;
    while (idx < p_live) begin
      a = p_age[idx];
      a = (a > 32'hFFFFFFFF - dt) ? 32'hFFFFFFFF : a + dt;
      p_age[idx] = a;
      if (a >= p_life[idx]) begin
        p_age[idx] = p_age[p_live - 1];
        p_life[idx] = p_life[p_live - 1];
        p_live = p_live - 1;
        t.retired_count = t.retired_count + 1;
      end else begin
        idx++;
      end
    end
    dsq = sq_mag(f.camera_dx) + sq_mag(f.camera_dy) + sq_mag(f.camera_dz);
    maxd = (p_dist < 32'd6554) ? 32'd6554 : p_dist;
    if (!f.emitter_visible || dsq > {32'd0, maxd} * {32'd0, maxd} || dt == 0) begin
      t.culled = 1;
    end else begin
      cam_range = int_sqrt(dsq);
      fd = (p_fade < maxd) ? p_fade : maxd;
      scale = 32'd65536;
      if (cam_range > fd && maxd > fd) begin
        q = ({32'd0, cam_range - fd} << 16) / {32'd0, maxd - fd};
        scale = (q >= 65536) ? 32'd0 : 32'd65536 - q[31:0];
      end
      dens = (f.density_scale > 32'd65536) ? 32'd65536 : f.density_scale;
      comb = ({32'd0, dens} * {32'd0, scale}) >> 16;
      inc = {64'd0, p_rate} * {64'd0, comb} * {64'd0, dt};
      p_debt = p_debt + inc[63:32];
      want = p_debt >> 16;
      cap = p_max / 4;
      if (cap < 1) cap = 1;
      if (cap > 128) cap = 128;
      if (want > cap) want = cap;
      p_debt = p_debt - (want << 16);
      lim = (p_max < 1) ? 32'd1 : p_max;
      if (lim > SLOTS) lim = SLOTS;
      for (int i = 0; i < want; i++) begin
        if (p_live >= lim) begin
          t.dropped_count = t.dropped_count + 1;
        end else begin
          for (int k = 0; k < 6; k++) void'(gen_step());
          r = gen_step() & 32'h00FFFFFF;
          void'(gen_step());
          void'(gen_step());
          lo = p_lo;
          hi = p_hi;
          if (hi < lo) begin
            lo = p_hi;
            hi = p_lo;
          end
          lm = ({32'd0, hi - lo} * {32'd0, r}) >> 24;
          life = lo + lm[31:0];
          if (life < 32'd655) life = 32'd655;
          p_age[p_live] = 0;
          p_life[p_live] = life;
          p_live = p_live + 1;
          t.spawned_count = t.spawned_count + 1;
        end
      end
      if (p_debt > 32'd131072) p_debt = 32'd131072;
    end
    t.alive_count = p_live[16:0];
    return t;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 3000);
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("Simulation FAILED");
    $finish;
  end

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 0;
    end else if (in_if.valid && !in_if.ready) begin
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_if.valid <= 0;
    end else if (frame_q.size() != 0 && !feed_hold) begin
      frame_t f;
      f = frame_q.pop_front();
      tally_q.push_back(predict_tally(f));
      in_if.valid <= 1;
      {in_if.frame_dt, in_if.camera_dx, in_if.camera_dy, in_if.camera_dz,
       in_if.emitter_visible, in_if.density_scale} <= f;
      in_gap <= gap_len();
    end else begin
      in_if.valid <= 0;
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        tally_t got, exp_t;
        got = {out_if.retired_count, out_if.spawned_count, out_if.dropped_count,
               out_if.culled, out_if.alive_count};
        if (tally_q.size() == 0) begin
          $display("%0t: unexpected item %h", $time, got);
          errors++;
        end else begin
          exp_t = tally_q.pop_front();
          if (got.retired_count !== exp_t.retired_count)
            $display("%0t: retired exp %0d got %0d", $time, exp_t.retired_count, got.retired_count);
          if (got.spawned_count !== exp_t.spawned_count)
            $display("%0t: spawned exp %0d got %0d", $time, exp_t.spawned_count, got.spawned_count);
          if (got.dropped_count !== exp_t.dropped_count)
            $display("%0t: dropped exp %0d got %0d", $time, exp_t.dropped_count, got.dropped_count);
          if (got.culled !== exp_t.culled)
            $display("%0t: culled exp %0d got %0d", $time, exp_t.culled, got.culled);
          if (got.alive_count !== exp_t.alive_count)
            $display("%0t: alive exp %0d got %0d", $time, exp_t.alive_count, got.alive_count);
          if (got !== exp_t) errors++;
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_if.ready <= 0;
      end else begin
        out_if.ready <= 1;
        out_gap <= gap_len();
      end
    end
  end

  task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] v);
    @(posedge clk);
    cfg_if.valid <= 1;
    cfg_if.index <= idx;
    cfg_if.wdata <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 0;
    write_reg_model(idx, v);
  endtask

  task automatic drain();
    while (frame_q.size() != 0 || in_if.valid || tally_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [31:0] near_cam();
    logic [31:0] v;
    v = $urandom_range(0, 40 * 65536);
    return ($urandom_range(0, 1) != 0) ? -v : v;
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    int s;
    s = $urandom_range(0, 9);
    f.frame_dt = (s == 0) ? $urandom() : (s == 1) ? 32'd0 : $urandom_range(1, 3277);
    f.camera_dx = (s == 2) ? $urandom() : near_cam();
    f.camera_dy = (s == 3) ? $urandom() : near_cam();
    f.camera_dz = (s == 4) ? $urandom() : near_cam();
    f.emitter_visible = (s != 5);
    f.density_scale = (s == 6) ? $urandom() : $urandom_range(0, 65536);
    return f;
  endfunction

  task automatic push_frame(input logic [31:0] dt, dx, dy, dz, input logic vis,
                            input logic [31:0] dens);
    frame_t f;
    f = {dt, dx, dy, dz, vis, dens};
    frame_q.push_back(f);
  endtask

  initial begin
    frame_t f;
    rst_n = 0;
    in_if.valid = 0;
    in_if.frame_dt = 0; in_if.camera_dx = 0; in_if.camera_dy = 0; in_if.camera_dz = 0;
    in_if.emitter_visible = 0; in_if.density_scale = 0;
    out_if.ready = 0;
    cfg_if.valid = 0; cfg_if.index = CFG_SPAWN_RATE; cfg_if.wdata = 0;
    p_rate = 0; p_max = 1024; p_dist = 3276800; p_fade = 0;
    p_lo = 65536; p_hi = 131072; p_live = 0; p_debt = 0; p_gen = 32'h584A4945;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed
    cfg_write(CFG_SPAWN_RATE, 32'd2000 << 16);
    cfg_write(CFG_FADE_START, 32'd10 << 16);
    push_frame(3277, 0, 0, 0, 1, 65536);
    push_frame(32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1, 32'hFFFFFFFF);
    push_frame(0, 0, 0, 0, 1, 65536);
    push_frame(3277, 0, 0, 0, 0, 65536);
    push_frame(3277, 32'd49 << 16, 0, 0, 1, 65536);
    push_frame(3277, 32'hFFD00000, 32'd5 << 16, 32'd1, 1, 32'hFFFFFFFF);
    push_frame(1, 0, 0, 0, 1, 0);
    repeat (8) push_frame(3277, 0, 0, 0, 1, 65536);
    drain();
    cfg_write(CFG_MAX_ALIVE, 0);
    cfg_write(CFG_LIFETIME_LOW, 32'hFFFFFFFF);
    cfg_write(CFG_LIFETIME_HIGH, 0);
    cfg_write(CFG_SPAWN_DIST, 0);
    push_frame(3277, 0, 0, 0, 1, 65536);
    push_frame(3277, 32'd6554, 0, 0, 1, 65536);
    push_frame(3277, 32'd6555, 0, 0, 1, 65536);
    drain();
    cfg_write(CFG_RANDOM_SEED, 0);
    cfg_write(CFG_MAX_ALIVE, 32'd65536);
    cfg_write(CFG_SPAWN_RATE, 32'hFFFFFFFF);
    cfg_write(CFG_LIFETIME_LOW, 0);
    cfg_write(CFG_LIFETIME_HIGH, 32'd3000);
    cfg_write(CFG_SPAWN_DIST, 32'hFFFFFFFF);
    cfg_write(CFG_FADE_START, 32'hFFFFFFFF);
    repeat (4) push_frame(3277, 32'h80000000, 32'h80000000, 32'h80000000, 1, 65536);
    drain();

    // random phases
    for (int ph = 0; ph < 10; ph++) begin
      cfg_write(CFG_SPAWN_RATE, $urandom_range(0, 4) == 0 ? $urandom() :
                $urandom_range(0, 3000) << 16);
      cfg_write(CFG_MAX_ALIVE, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65536) :
                $urandom_range(0, 300));
      cfg_write(CFG_SPAWN_DIST, $urandom_range(0, 4) == 0 ? $urandom() :
                $urandom_range(0, 60 << 16));
      cfg_write(CFG_FADE_START, $urandom_range(0, 40 << 16));
      cfg_write(CFG_LIFETIME_LOW, $urandom_range(0, 3) == 0 ? $urandom() :
                $urandom_range(0, 20000));
      cfg_write(CFG_LIFETIME_HIGH, $urandom_range(0, 40000));
      if (ph % 3 == 0) cfg_write(CFG_RANDOM_SEED, $urandom());
      for (int n = 0; n < 50; n++) begin
        f = rand_frame();
        frame_q.push_back(f);
        if (n == 25 && ph == 4) begin
          while (frame_q.size() != 0) @(posedge clk);
          feed_hold = 1;
          while (in_if.valid || tally_q.size() != 0) @(posedge clk);
          feed_hold = 0;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/pse_pkg.sv
rtl/core/pse_ifs.sv
rtl/core/pse_mul.sv
rtl/core/pse_slot_mem.sv
rtl/core/particle_spawn_retire_engine_top.sv
tb/pse_tb_ifs.sv
tb/particle_spawn_retire_engine_top_tb.sv
